[rtl/glt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glt_pkg
// Shared types and constants of the glyph text layout and clip engine.
// ----------------------------------------------------------------------------
package glt_pkg;

    localparam int FIRST_CHAR    = 33;
    localparam int GLYPH_ENTRIES = 256;
    localparam int GLYPH_ADDR_W  = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int GLYPH_W       = 36;
    localparam int CALC_W        = 20;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [7:0] SPACE_CODE = 8'd32;

    typedef logic signed [CALC_W-1:0] calc_t;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_CHAR  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPACE_WIDTH  = 3'd0,
        REG_GLYPH_HEIGHT = 3'd1,
        REG_LAST_CHAR    = 3'd2,
        REG_CLIP_LEFT    = 3'd3,
        REG_CLIP_TOP     = 3'd4,
        REG_CLIP_WIDTH   = 3'd5,
        REG_CLIP_HEIGHT  = 3'd6,
        REG_UNUSED       = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         glyph_index;
        logic [11:0]        entry_column;
        logic [7:0]         entry_width;
        logic signed [7:0]  entry_offset;
        logic [7:0]         entry_advance;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [7:0]         char_code;
    } in_t;

    typedef struct packed {
        logic               drawn;
        logic [11:0]        src_x;
        logic [7:0]         src_y;
        logic [7:0]         rect_width;
        logic [7:0]         rect_height;
        logic signed [15:0] dst_x;
        logic signed [15:0] dst_y;
        logic               stopped;
    } out_t;

    typedef struct packed {
        logic [11:0]       column;
        logic [7:0]        width;
        logic signed [7:0] offset;
        logic [7:0]        advance;
    } glyph_t;

    typedef struct packed {
        logic [7:0]         space_width;
        logic [7:0]         glyph_height;
        logic [7:0]         last_char;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic [14:0]        clip_width;
        logic [14:0]        clip_height;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               done;
    } pen_t;

endpackage

[rtl/glyph_text_layout_clip.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_layout_clip
// Bitmap font text layout: glyph table load, pen placement and clipped blit
// rectangles, one transaction per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Pipeline: glyph RAM read and item register, then clip and pen update
//   into the result register. The pen loop closes within the clip stage.
// Throughput: one item per cycle unless the output stalls.
// Reset: aresetn clears pen, stop flag, configuration registers and valid
//   flags; the glyph table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module glyph_text_layout_clip (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  glt_pkg::in_t                          s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output glt_pkg::out_t                         m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [glt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [glt_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import glt_pkg::*;

    logic                    s_accept;
    logic                    s1_move;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    in_t                     s1_data_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    out_t                    m_data_reg;
    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    pen_t                    pen_reg;
    pen_t                    pen_next;
    out_t                    result;
    glyph_t                  glyph;
    logic [GLYPH_W-1:0]      glyph_raw;
    logic                    wr_en;
    logic [7:0]              rd_code;
    logic                    s1_is_char;

    assign cfg_ready  = 1'b1;
    assign s1_is_char = (cmd_t'(s1_data_reg.cmd) == CMD_CHAR);
    assign s1_move    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_move;
    assign s_accept   = s_valid && s_ready;

    assign wr_en   = s_accept && (cmd_t'(s_data.cmd) == CMD_LOAD)
                  && (32'(s_data.glyph_index) < 32'(GLYPH_ENTRIES));
    assign rd_code = s_data.char_code - 8'(FIRST_CHAR);

    glt_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_ENTRIES)
    ) u_glyph_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_data.glyph_index[GLYPH_ADDR_W-1:0]),
        .wr_data ({s_data.entry_column, s_data.entry_width,
                   s_data.entry_offset, s_data.entry_advance}),
        .rd_en   (s_accept),
        .rd_addr (rd_code[GLYPH_ADDR_W-1:0]),
        .rd_data (glyph_raw)
    );

    assign glyph = glyph_t'(glyph_raw);

    glt_clip u_clip (
        .item     (s1_data_reg),
        .glyph    (glyph),
        .cfg      (cfg_reg),
        .pen      (pen_reg),
        .result   (result),
        .pen_next (pen_next)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                REG_SPACE_WIDTH:  cfg_next.space_width  = cfg_data[7:0];
                REG_GLYPH_HEIGHT: cfg_next.glyph_height = cfg_data[7:0];
                REG_LAST_CHAR:    cfg_next.last_char    = cfg_data[7:0];
                REG_CLIP_LEFT:    cfg_next.clip_left    = cfg_data;
                REG_CLIP_TOP:     cfg_next.clip_top     = cfg_data;
                REG_CLIP_WIDTH:   cfg_next.clip_width   = cfg_data[14:0];
                REG_CLIP_HEIGHT:  cfg_next.clip_height  = cfg_data[14:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_move) begin
            m_valid_next = s1_is_char;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cfg_reg      <= '0;
            pen_reg      <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            cfg_reg      <= cfg_next;
            if (s1_move) begin
                pen_reg <= pen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_data_reg <= s_data;
        end
        if (s1_move && s1_is_char) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/glt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glt_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module glt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/glt_clip.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glt_clip
// Glyph rectangle clipping and pen update for one registered item.
// ----------------------------------------------------------------------------
module glt_clip (
    input  glt_pkg::in_t    item,
    input  glt_pkg::glyph_t glyph,
    input  glt_pkg::cfg_t   cfg,
    input  glt_pkg::pen_t   pen,
    output glt_pkg::out_t   result,
    output glt_pkg::pen_t   pen_next
);

    import glt_pkg::*;

    logic  is_char;
    logic  is_space;
    logic  is_glyph;
    calc_t pen_x;
    calc_t pen_y;
    calc_t clip_l;
    calc_t clip_t;
    calc_t clip_r;
    calc_t clip_b;
    calc_t dx0;
    calc_t dy0;
    calc_t d_l;
    calc_t d_t;
    calc_t sx;
    calc_t sy;
    calc_t dx1;
    calc_t dy1;
    calc_t w1;
    calc_t h1;
    calc_t lim_w;
    calc_t lim_h;
    calc_t w2;
    calc_t h2;
    calc_t w3;
    calc_t h3;
    calc_t adv;
    calc_t px_sum;
    calc_t px_new;
    calc_t px_final;

    assign is_char  = (cmd_t'(item.cmd) == CMD_CHAR);
    assign is_space = (item.char_code == SPACE_CODE);
    assign is_glyph = !is_space
                   && (32'(item.char_code) >= 32'(FIRST_CHAR))
                   && (item.char_code <= cfg.last_char)
                   && ((32'(item.char_code) - 32'(FIRST_CHAR)) < 32'(GLYPH_ENTRIES));

    assign pen_x  = calc_t'(pen.x);
    assign pen_y  = calc_t'(pen.y);
    assign clip_l = calc_t'(cfg.clip_left);
    assign clip_t = calc_t'(cfg.clip_top);
    assign clip_r = clip_l + calc_t'({1'b0, cfg.clip_width});
    assign clip_b = clip_t + calc_t'({1'b0, cfg.clip_height});

    assign dx0 = pen_x - calc_t'(glyph.offset);
    assign dy0 = pen_y;
    assign d_l = clip_l - dx0;
    assign d_t = clip_t - dy0;

    always_comb begin
        if (d_l > 0) begin
            sx  = calc_t'({1'b0, glyph.column}) + d_l;
            dx1 = clip_l;
            w1  = calc_t'({1'b0, glyph.width}) - d_l;
        end else begin
            sx  = calc_t'({1'b0, glyph.column});
            dx1 = dx0;
            w1  = calc_t'({1'b0, glyph.width});
        end
        if (d_t > 0) begin
            sy  = calc_t'(1) + d_t;
            dy1 = clip_t;
            h1  = calc_t'({1'b0, cfg.glyph_height}) - d_t;
        end else begin
            sy  = calc_t'(1);
            dy1 = dy0;
            h1  = calc_t'({1'b0, cfg.glyph_height});
        end
    end

    assign lim_w = clip_r - dx1;
    assign lim_h = clip_b - dy1;
    assign w2    = (w1 > lim_w) ? lim_w : w1;
    assign h2    = (h1 > lim_h) ? lim_h : h1;
    assign w3    = (w2 < 0) ? calc_t'(0) : w2;
    assign h3    = (h2 < 0) ? calc_t'(0) : h2;

    assign adv      = is_space ? calc_t'({1'b0, cfg.space_width})
                               : calc_t'({1'b0, glyph.advance});
    assign px_sum   = pen_x + adv;
    assign px_new   = (px_sum > calc_t'(32767)) ? calc_t'(32767) : px_sum;
    assign px_final = (is_space || is_glyph) ? px_new : pen_x;

    always_comb begin
        pen_next = pen;
        result   = '0;
        if (cmd_t'(item.cmd) == CMD_START) begin
            pen_next.x    = item.start_x;
            pen_next.y    = item.start_y;
            pen_next.done = 1'b0;
        end else if (is_char) begin
            if (pen.done) begin
                result.stopped = 1'b1;
            end else begin
                pen_next.x     = px_final[15:0];
                pen_next.done  = (px_final > clip_r);
                result.stopped = (px_final > clip_r);
                if (is_glyph) begin
                    result.drawn       = 1'b1;
                    result.src_x       = (sx > calc_t'(4095)) ? 12'hFFF : sx[11:0];
                    result.src_y       = (sy > calc_t'(255)) ? 8'hFF : sy[7:0];
                    result.rect_width  = w3[7:0];
                    result.rect_height = h3[7:0];
                    if (dx1 > calc_t'(32767)) begin
                        result.dst_x = 16'sh7FFF;
                    end else if (dx1 < calc_t'(-32768)) begin
                        result.dst_x = -16'sh8000;
                    end else begin
                        result.dst_x = dx1[15:0];
                    end
                    result.dst_y = dy1[15:0];
                end
            end
        end
    end

endmodule
